// ===== src/dssp_pkg.sv =====
// shared types and constants of the diffusion step skip policy
package dssp_pkg;

  localparam int STEP_W    = 10;
  localparam int ELEM_W    = 32;
  localparam int SUM_W     = 40;
  localparam int CNT_W     = 16;
  localparam int DIST_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIVD_W    = SUM_W + FRAC_W;
  localparam int DIVS_W    = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_ENABLE   = 3'd0,
    CFG_SKIP_INTERVAL  = 3'd1,
    CFG_WARMUP_LEN     = 3'd2,
    CFG_DISTANCE_LIMIT = 3'd3,
    CFG_TOTAL_STEPS    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_WAIT,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              elem_acc;
    logic              use_prev;
    logic              clear;
    logic [ELEM_W-1:0] value;
  } sig_ctrl_t;

  typedef struct packed {
    logic             rd_valid;
    logic             pos_nz;
    logic             pos_last;
    logic [SUM_W-1:0] diff_sum;
    logic [SUM_W-1:0] ref_sum;
  } sig_stat_t;

endpackage

// ===== src/dssp_in_if.sv =====
// input channel: one signature element or a no-code marker per item
interface dssp_in_if;
  import dssp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STEP_W-1:0]        step_index;
  logic signed [ELEM_W-1:0] elem_value;
  logic                     last_elem;
  logic                     no_code;

  modport source (output valid, step_index, elem_value, last_elem, no_code, input ready);
  modport sink   (input valid, step_index, elem_value, last_elem, no_code, output ready);
endinterface

// ===== src/dssp_out_if.sv =====
// output channel: one compute/skip decision per step
interface dssp_out_if;
  import dssp_pkg::*;

  logic             valid;
  logic             ready;
  logic             compute_now;
  logic [CNT_W-1:0] computed_total;
  logic [CNT_W-1:0] skipped_total;

  modport source (output valid, compute_now, computed_total, skipped_total, input ready);
  modport sink   (input valid, compute_now, computed_total, skipped_total, output ready);
endinterface

// ===== src/diffusion_step_skip_policy.sv =====
// per-step compute/skip decision from relative L1 distance of step signatures
// signature elements are taken one at a time, ready dropping after each (memory read, then update)
// step end to result: ST_WAIT, ST_EVAL, then ST_FIN when forced or no division is needed,
// with ST_DIV before ST_FIN when the serial divider runs (56 quotient bits, one per cycle)
// reset clears control state, sums and counters; the signature memory is not
// cleared and holds no valid data until a full signature has been written
module diffusion_step_skip_policy #(
  parameter int SIG_LEN    = 64,
  parameter int MIN_WARMUP = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dssp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dssp_pkg::CFG_W-1:0]     cfg_data_i,
  dssp_in_if.sink                        in_i,
  dssp_out_if.source                     out_o
);
  import dssp_pkg::*;

  localparam logic [STEP_W-1:0] MinWarm = STEP_W'(MIN_WARMUP);

  logic              cache_enable_q;
  logic [STEP_W-1:0] skip_interval_q;
  logic [STEP_W-1:0] warmup_len_q;
  logic [DIST_W-1:0] distance_limit_q;
  logic [STEP_W-1:0] total_steps_q;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              present_q, present_d;
  logic              full_q, full_d;
  logic              mode_mod_q, mode_mod_d;
  logic              need_cmp_q, need_cmp_d;
  logic              compute_q, compute_d;
  logic              have_prev_q, have_prev_d;
  logic [DIST_W-1:0] accum_q, accum_d;
  logic [CNT_W-1:0]  computed_q, computed_d;
  logic [CNT_W-1:0]  skipped_q, skipped_d;
  logic              out_valid_q, out_valid_d;
  logic              out_compute_q, out_compute_d;

  sig_ctrl_t         sig_ctrl;
  sig_stat_t         sig_stat;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_acc;
  logic [STEP_W-1:0] warm;
  logic              forced;
  logic [DIST_W-1:0] qsat;
  logic [DIST_W:0]   asum;
  logic              compute;
  logic              fin_fire;

  dssp_sig #(.SIG_LEN(SIG_LEN)) u_sig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sig_ctrl),
    .stat_o (sig_stat)
  );

  dssp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == ST_RUN) && sig_stat.rd_valid;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_enable_q   <= 1'b0;
      skip_interval_q  <= '0;
      warmup_len_q     <= STEP_W'(2);
      distance_limit_q <= '0;
      total_steps_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CACHE_ENABLE:   cache_enable_q   <= cfg_data_i[0];
        CFG_SKIP_INTERVAL:  skip_interval_q  <= cfg_data_i[STEP_W-1:0];
        CFG_WARMUP_LEN:     warmup_len_q     <= cfg_data_i[STEP_W-1:0];
        CFG_DISTANCE_LIMIT: distance_limit_q <= cfg_data_i[DIST_W-1:0];
        CFG_TOTAL_STEPS:    total_steps_q    <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    warm   = (warmup_len_q < MinWarm) ? MinWarm : warmup_len_q;
    forced = !cache_enable_q || (step_q < warm) ||
             (({1'b0, step_q} + 1'b1) >= {1'b0, total_steps_q});
    qsat   = (|div_rsp.quot[DIVD_W-1:DIST_W]) ? '1 : div_rsp.quot[DIST_W-1:0];
    asum   = {1'b0, accum_q} + {1'b0, qsat};
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    present_d     = present_q;
    full_d        = full_q;
    mode_mod_d    = mode_mod_q;
    need_cmp_d    = need_cmp_q;
    compute_d     = compute_q;
    have_prev_d   = have_prev_q;
    accum_d       = accum_q;
    computed_d    = computed_q;
    skipped_d     = skipped_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_compute_d = out_compute_q;
    compute       = need_cmp_q ? (accum_q >= distance_limit_q) : compute_q;
    fin_fire      = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = DIVD_W'(step_q);
    div_req.divisor  = DIVS_W'(skip_interval_q);

    unique case (state_q)
      ST_RUN: begin
        if (in_acc && in_i.no_code) begin
          step_d    = in_i.step_index;
          present_d = 1'b0;
          full_d    = 1'b0;
          // a partial signature is abandoned
          if (sig_stat.pos_nz) begin
            have_prev_d = 1'b0;
          end
          state_d = ST_WAIT;
        end else if (in_acc && in_i.last_elem) begin
          step_d    = in_i.step_index;
          present_d = 1'b1;
          full_d    = sig_stat.pos_last;
          state_d   = ST_WAIT;
        end
      end
      // last element's sums land during this cycle
      ST_WAIT: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        need_cmp_d = 1'b0;
        compute_d  = 1'b1;
        if (forced) begin
          state_d = ST_FIN;
        end else if (skip_interval_q != '0) begin
          div_req.start = 1'b1;
          mode_mod_d    = 1'b1;
          state_d       = ST_DIV;
        end else if (have_prev_q && full_q && sig_stat.ref_sum != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {sig_stat.diff_sum, {FRAC_W{1'b0}}};
          div_req.divisor  = sig_stat.ref_sum;
          mode_mod_d       = 1'b0;
          state_d          = ST_DIV;
        end else begin
          need_cmp_d = 1'b1;
          state_d    = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (mode_mod_q) begin
            compute_d  = div_rsp.rem == '0;
            need_cmp_d = 1'b0;
          end else begin
            accum_d    = asum[DIST_W] ? '1 : asum[DIST_W-1:0];
            need_cmp_d = 1'b1;
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          fin_fire      = 1'b1;
          out_valid_d   = 1'b1;
          out_compute_d = compute;
          if (compute) begin
            accum_d    = '0;
            computed_d = (computed_q == '1) ? computed_q : computed_q + 1'b1;
          end else begin
            skipped_d = (skipped_q == '1) ? skipped_q : skipped_q + 1'b1;
          end
          if (present_q) begin
            have_prev_d = full_q;
          end
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase

    sig_ctrl.elem_acc = in_acc && !in_i.no_code;
    sig_ctrl.use_prev = have_prev_q;
    sig_ctrl.clear    = fin_fire;
    sig_ctrl.value    = in_i.elem_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      present_q   <= 1'b0;
      full_q      <= 1'b0;
      mode_mod_q  <= 1'b0;
      need_cmp_q  <= 1'b0;
      compute_q   <= 1'b0;
      have_prev_q <= 1'b0;
      accum_q     <= '0;
      computed_q  <= '0;
      skipped_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      full_q      <= full_d;
      mode_mod_q  <= mode_mod_d;
      need_cmp_q  <= need_cmp_d;
      compute_q   <= compute_d;
      have_prev_q <= have_prev_d;
      accum_q     <= accum_d;
      computed_q  <= computed_d;
      skipped_q   <= skipped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q        <= step_d;
    out_compute_q <= out_compute_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.compute_now    = out_compute_q;
  assign out_o.computed_total = computed_q;
  assign out_o.skipped_total  = skipped_q;

endmodule

// ===== src/dssp_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module dssp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dssp_pkg::div_req_t  req_i,
  output dssp_pkg::div_rsp_t  rsp_o
);
  import dssp_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(DIVD_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0]    dvd_q;
  logic [DIVS_W-1:0]    rem_q;
  logic [DIVS_W-1:0]    dvs_q;

  logic [DIVS_W:0]      rem_sh;
  logic [DIVS_W+1:0]    sub;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DIVD_W-1]};
    sub    = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = !sub[DIVS_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIVD_W-2:0], ge};
      rem_q <= ge ? sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/dssp_sig.sv =====
// previous-signature memory with read-modify-write and L1 sum accumulation
module dssp_sig #(
  parameter int SIG_LEN = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dssp_pkg::sig_ctrl_t  ctrl_i,
  output dssp_pkg::sig_stat_t  stat_o
);
  import dssp_pkg::*;

  localparam int POS_W = $clog2(SIG_LEN + 2);
  localparam int IDX_W = (SIG_LEN > 1) ? $clog2(SIG_LEN) : 1;
  localparam logic [POS_W-1:0] PosLen  = POS_W'(SIG_LEN);
  localparam logic [POS_W-1:0] PosLast = POS_W'(SIG_LEN - 1);

  logic [ELEM_W-1:0] mem [SIG_LEN];
  logic [ELEM_W-1:0] rd_data_q;
  logic              rd_valid_q;
  logic [POS_W-1:0]  pos_q;
  logic [IDX_W-1:0]  addr;
  logic              pos_in;

  logic [ELEM_W:0]   ad_q;
  logic [ELEM_W-1:0] ar_q;
  logic              add_pend_q;
  logic [SUM_W-1:0]  diff_sum_q;
  logic [SUM_W-1:0]  ref_sum_q;

  logic [ELEM_W:0]   d;
  logic [ELEM_W:0]   ad;
  logic [ELEM_W-1:0] ar;
  logic [SUM_W:0]    dsum;
  logic [SUM_W:0]    rsum;

  assign pos_in = pos_q < PosLen;
  assign addr   = pos_in ? pos_q[IDX_W-1:0] : '0;

  always_comb begin
    d    = {ctrl_i.value[ELEM_W-1], ctrl_i.value} - {rd_data_q[ELEM_W-1], rd_data_q};
    ad   = d[ELEM_W] ? (~d + 1'b1) : d;
    ar   = rd_data_q[ELEM_W-1] ? (~rd_data_q + 1'b1) : rd_data_q;
    dsum = {1'b0, diff_sum_q} + (SUM_W + 1)'(ad_q);
    rsum = {1'b0, ref_sum_q} + (SUM_W + 1)'(ar_q);
  end

  // read data follows the position in the next cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.elem_acc && pos_in) begin
      mem[addr] <= ctrl_i.value;
    end
    rd_data_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    ad_q <= ad;
    ar_q <= ar;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      pos_q      <= '0;
      add_pend_q <= 1'b0;
      diff_sum_q <= '0;
      ref_sum_q  <= '0;
    end else begin
      rd_valid_q <= !(ctrl_i.elem_acc || ctrl_i.clear);
      add_pend_q <= ctrl_i.elem_acc && pos_in && ctrl_i.use_prev;
      if (ctrl_i.clear) begin
        pos_q      <= '0;
        diff_sum_q <= '0;
        ref_sum_q  <= '0;
      end else begin
        if (ctrl_i.elem_acc && pos_q <= PosLen) begin
          pos_q <= pos_q + 1'b1;
        end
        if (add_pend_q) begin
          diff_sum_q <= dsum[SUM_W] ? '1 : dsum[SUM_W-1:0];
          ref_sum_q  <= rsum[SUM_W] ? '1 : rsum[SUM_W-1:0];
        end
      end
    end
  end

  assign stat_o.rd_valid = rd_valid_q;
  assign stat_o.pos_nz   = pos_q != '0;
  assign stat_o.pos_last = pos_q == PosLast;
  assign stat_o.diff_sum = diff_sum_q;
  assign stat_o.ref_sum  = ref_sum_q;

endmodule

// ===== src/dssp_checker.sv =====
// port-level checks of the step skip policy, bound to the top level
module dssp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       compute_now_i,
  input logic [dssp_pkg::CNT_W-1:0] computed_total_i,
  input logic [dssp_pkg::CNT_W-1:0] skipped_total_i
);
  import dssp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(compute_now_i) &&
      $stable(computed_total_i) && $stable(skipped_total_i))
    else $error("result changed while stalled");

  // input ready is low in the cycle after every accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item accepted in back-to-back cycles");

  // a new result never appears right after an item was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc))
    else $error("result too soon after item");

  // a computed decision carries a nonzero computed count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && compute_now_i |-> computed_total_i != '0)
    else $error("computed count missing");

endmodule

bind diffusion_step_skip_policy dssp_checker u_dssp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .compute_now_i    (out_o.compute_now),
  .computed_total_i (out_o.computed_total),
  .skipped_total_i  (out_o.skipped_total)
);

// ===== bench/diffusion_step_skip_policy_test.sv =====
// self-checking testbench of the diffusion step skip policy: predicts every decision
module diffusion_step_skip_policy_test;
  import dssp_pkg::*;

  localparam int SIG_LEN      = 64;
  localparam int SIG_IDX_W    = $clog2(SIG_LEN);
  localparam int MIN_WARMUP   = 2;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 205;

  typedef enum int {SK_FULL, SK_NOCODE, SK_SHORT, SK_LONG, SK_ABANDON} step_kind_e;
  typedef enum int {SIG_PERTURB, SIG_RANDOM, SIG_SAME, SIG_ZERO, SIG_EXTREME, SIG_TINY} sig_mode_e;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [ELEM_W-1:0] value;
    logic              last;
    logic              no_code;
  } elem_item_t;

  typedef struct packed {
    logic             compute;
    logic [CNT_W-1:0] computed;
    logic [CNT_W-1:0] skipped;
  } decision_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  dssp_in_if  in_if ();
  dssp_out_if out_if ();

  diffusion_step_skip_policy #(
    .SIG_LEN    (SIG_LEN),
    .MIN_WARMUP (MIN_WARMUP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  elem_item_t pend_q[$];
  decision_t  decision_q[$];
  int         errors;
  int         results_seen;
  int         idle_pct;
  int         cycle_cnt;
  logic       hold_off;

  // predictor copy of configuration and state
  logic              pm_cache_en;
  logic [STEP_W-1:0] pm_interval;
  logic [STEP_W-1:0] pm_warmup;
  logic [DIST_W-1:0] pm_limit;
  logic [STEP_W-1:0] pm_total;
  logic [ELEM_W-1:0] pm_prev_sig [SIG_LEN];
  logic              pm_have_prev;
  logic [DIST_W-1:0] pm_accum;
  logic [SUM_W-1:0]  pm_diff_sum;
  logic [SUM_W-1:0]  pm_ref_sum;
  int                pm_pos;
  logic [CNT_W-1:0]  pm_computed;
  logic [CNT_W-1:0]  pm_skipped;

  // generator side copy of the last signature sent, for similar signatures
  logic [ELEM_W-1:0] last_sig [SIG_LEN];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("diffusion_step_skip_policy_test: FAIL");
      $finish;
    end
  end

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] step_distance();
    logic [63:0] q;
    if (pm_ref_sum == '0) return '0;
    q = {8'h0, pm_diff_sum, 16'h0} / {24'h0, pm_ref_sum};
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic void close_step(logic [STEP_W-1:0] step, logic present, logic full);
    logic [STEP_W-1:0] warm;
    logic              forced;
    logic              compute;
    logic [DIST_W:0]   s;
    decision_t         dec;
    warm    = (pm_warmup < MIN_WARMUP) ? STEP_W'(MIN_WARMUP) : pm_warmup;
    forced  = !pm_cache_en || step < warm || (int'(step) + 1) >= int'(pm_total);
    compute = 1'b1;
    if (!forced) begin
      if (pm_interval != '0) begin
        compute = (step % pm_interval) == '0;
      end else begin
        if (pm_have_prev && full) begin
          s = {1'b0, pm_accum} + {1'b0, step_distance()};
          pm_accum = s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
        end
        compute = pm_accum >= pm_limit;
      end
    end
    if (compute) pm_accum = '0;
    if (present) pm_have_prev = full;
    if (compute) begin
      if (pm_computed != {CNT_W{1'b1}}) pm_computed++;
    end else begin
      if (pm_skipped != {CNT_W{1'b1}}) pm_skipped++;
    end
    pm_diff_sum = '0;
    pm_ref_sum  = '0;
    pm_pos      = 0;
    dec.compute  = compute;
    dec.computed = pm_computed;
    dec.skipped  = pm_skipped;
    decision_q.insert(decision_q.size(), dec);
  endfunction

  function automatic void predict_item(elem_item_t it);
    longint            ps;
    longint            d;
    logic [SUM_W-1:0]  mag;
    if (it.no_code) begin
      // partial signature is dropped
      if (pm_pos > 0) pm_have_prev = 1'b0;
      close_step(it.step, 1'b0, 1'b0);
      return;
    end
    if (pm_pos < SIG_LEN) begin
      if (pm_have_prev) begin
        ps  = longint'($signed(pm_prev_sig[SIG_IDX_W'(pm_pos)]));
        d   = longint'($signed(it.value)) - ps;
        mag = (d < 0) ? SUM_W'(-d) : SUM_W'(d);
        pm_diff_sum = sat_sum(pm_diff_sum, mag);
        mag = (ps < 0) ? SUM_W'(-ps) : SUM_W'(ps);
        pm_ref_sum  = sat_sum(pm_ref_sum, mag);
      end
      pm_prev_sig[SIG_IDX_W'(pm_pos)] = it.value;
    end
    if (pm_pos <= SIG_LEN) pm_pos++;
    if (it.last) close_step(it.step, 1'b1, pm_pos == SIG_LEN);
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  task automatic check_decision(decision_t got);
    decision_t want;
    if (decision_q.size() == 0) begin
      report($sformatf("decision with none pending: compute_now %0d", got.compute));
      return;
    end
    want = decision_q.pop_front();
    if (got.compute != want.compute)
      report($sformatf("compute_now got %0d, want %0d", got.compute, want.compute));
    if (got.computed != want.computed)
      report($sformatf("computed_total got %0d, want %0d", got.computed, want.computed));
    if (got.skipped != want.skipped)
      report($sformatf("skipped_total got %0d, want %0d", got.skipped, want.skipped));
  endtask

  // driver: offers the oldest pending item, holds it until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_item(pend_q[0]);
        void'(pend_q.pop_front());
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_if.valid      <= 1'b1;
          in_if.step_index <= pend_q[0].step;
          in_if.elem_value <= pend_q[0].value;
          in_if.last_elem  <= pend_q[0].last;
          in_if.no_code    <= pend_q[0].no_code;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each decision taken and throttles ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        check_decision({out_if.compute_now, out_if.computed_total, out_if.skipped_total});
      end
      if (hold_off) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    hold_off = 1'b0;
    while (!(results_seen >= 8 && pend_q.size() > 200)) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CACHE_ENABLE:   pm_cache_en = val[0];
      CFG_SKIP_INTERVAL:  pm_interval = val[STEP_W-1:0];
      CFG_WARMUP_LEN:     pm_warmup   = val[STEP_W-1:0];
      CFG_DISTANCE_LIMIT: pm_limit    = val[DIST_W-1:0];
      CFG_TOTAL_STEPS:    pm_total    = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic en, int interval, int warm, logic [31:0] limit, int total);
    write_reg(CFG_CACHE_ENABLE, {31'h0, en});
    write_reg(CFG_SKIP_INTERVAL, CFG_W'(interval));
    write_reg(CFG_WARMUP_LEN, CFG_W'(warm));
    write_reg(CFG_DISTANCE_LIMIT, limit);
    write_reg(CFG_TOTAL_STEPS, CFG_W'(total));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || decision_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_item(int step, logic [31:0] value, logic last, logic nc);
    elem_item_t it;
    it.step    = STEP_W'(step);
    it.value   = value;
    it.last    = last;
    it.no_code = nc;
    pend_q.insert(pend_q.size(), it);
  endtask

  function automatic logic [ELEM_W-1:0] gen_elem(sig_mode_e mode, int pos);
    int unsigned scale;
    logic [31:0] noise;
    if (pos >= SIG_LEN) return $urandom;
    case (mode)
      SIG_PERTURB: begin
        scale = 1 << $urandom_range(0, 20);
        noise = $urandom_range(0, 2 * scale) - scale;
        return last_sig[SIG_IDX_W'(pos)] + noise;
      end
      SIG_SAME:  return last_sig[SIG_IDX_W'(pos)];
      SIG_ZERO:  return '0;
      SIG_EXTREME: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      SIG_TINY:  return $urandom_range(0, 4) - 2;
      default:   return $urandom;
    endcase
  endfunction

  task automatic queue_step(int step, step_kind_e kind, sig_mode_e mode);
    int          len;
    int          stp;
    logic [31:0] v;
    case (kind)
      SK_FULL:   len = SIG_LEN;
      SK_LONG:   len = $urandom_range(SIG_LEN + 1, SIG_LEN + 4);
      SK_NOCODE: len = 0;
      default:   len = $urandom_range(1, SIG_LEN - 1);
    endcase
    for (int i = 0; i < len; i++) begin
      // step index only counts on the final item
      stp = (i == len - 1 || $urandom_range(9) != 0) ? step : $urandom_range(1023);
      v   = gen_elem(mode, i);
      if (i < SIG_LEN) last_sig[SIG_IDX_W'(i)] = v;
      push_item(stp, v, (i == len - 1) && kind != SK_ABANDON, 1'b0);
    end
    if (kind == SK_NOCODE || kind == SK_ABANDON)
      push_item(step, $urandom, 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic run_random_phase(int total);
    int         step;
    int         wrap;
    int         queued;
    int         r;
    step_kind_e kind;
    sig_mode_e  mode;
    step   = 0;
    queued = 0;
    wrap   = (total != 0) ? total + 2 : 64;
    while (queued < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 60) kind = SK_FULL;
      else if (r < 75) kind = SK_NOCODE;
      else if (r < 87) kind = SK_SHORT;
      else if (r < 92) kind = SK_LONG;
      else kind = SK_ABANDON;
      r = $urandom_range(99);
      if (r < 45) mode = SIG_PERTURB;
      else if (r < 60) mode = SIG_RANDOM;
      else if (r < 70) mode = SIG_SAME;
      else if (r < 75) mode = SIG_ZERO;
      else if (r < 85) mode = SIG_EXTREME;
      else mode = SIG_TINY;
      r = pend_q.size();
      queue_step(step, kind, mode);
      queued += pend_q.size() - r;
      if ($urandom_range(19) == 0) step = $urandom_range(1023);
      else step = (step + 1) % wrap;
    end
  endtask

  initial begin
    int total;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.step_index = '0;
    in_if.elem_value = '0;
    in_if.last_elem  = 1'b0;
    in_if.no_code    = 1'b0;
    out_if.ready     = 1'b0;
    errors           = 0;
    results_seen     = 0;
    cycle_cnt        = 0;
    idle_pct         = 31;
    pm_cache_en      = 1'b0;
    pm_interval      = '0;
    pm_warmup        = STEP_W'(2);
    pm_limit         = '0;
    pm_total         = '0;
    pm_have_prev     = 1'b0;
    pm_accum         = '0;
    pm_diff_sum      = '0;
    pm_ref_sum       = '0;
    pm_pos           = 0;
    pm_computed      = '0;
    pm_skipped       = '0;
    for (int i = 0; i < SIG_LEN; i++) begin
      pm_prev_sig[SIG_IDX_W'(i)] = '0;
      last_sig[SIG_IDX_W'(i)]    = $urandom;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // distance mode, warmup below the minimum
    set_config(1'b1, 0, 0, 32'h0000_8000, 1023);
    push_item(0, 32'h7FFF_FFFF, 1'b1, 1'b1);
    push_item(1023, 32'h8000_0000, 1'b0, 1'b1);
    push_item(10, 32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(10, 32'h8000_0000, 1'b1, 1'b0);
    // no-code in the middle of a signature
    push_item(11, 32'h0000_0000, 1'b0, 1'b0);
    push_item(11, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(11, 32'h1234_5678, 1'b1, 1'b1);
    push_item(1022, 32'h0000_0001, 1'b1, 1'b0);
    push_item(2, 32'h0001_0000, 1'b1, 1'b0);
    push_item(3, 32'h0, 1'b0, 1'b1);
    drain();

    // zero total steps forces every step
    set_config(1'b1, 5, 0, 32'h0, 0);
    push_item(7, 32'h5555_5555, 1'b0, 1'b1);
    push_item(500, 32'hAAAA_AAAA, 1'b1, 1'b1);
    push_item(9, 32'h8000_0000, 1'b1, 1'b0);
    drain();

    // fixed interval mode
    set_config(1'b1, 3, 0, 32'hFFFF_FFFF, 1023);
    for (int s = 2; s <= 7; s++) push_item(s, $urandom, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 8 || results_seen < 60; ph++) begin
      idle_pct = 31;
      case (ph % 8)
        0: begin total = 1023; set_config(1'b1, 0, 2, $urandom_range(32'h2000, 32'h20000), total); end
        1: begin
          total    = 1023;
          idle_pct = 0;
          set_config(1'b1, 0, 0, $urandom_range(32'h100, 32'h8000), total);
        end
        2: begin
          total = $urandom_range(1023);
          set_config(1'b0, $urandom_range(1023), $urandom_range(1023), $urandom, total);
        end
        3: begin
          total = $urandom_range(10, 40);
          set_config(1'b1, $urandom_range(1, 7), $urandom_range(0, 3), $urandom, total);
        end
        4: begin total = 1023; set_config(1'b1, 0, 0, 32'hFFFF_FFFF, total); end
        5: begin total = 1023; set_config(1'b1, 0, 1, 32'h0, total); end
        6: begin total = 1023; set_config(1'b1, 1023, 1023, 32'h0001_0000, total); end
        default: begin
          total = $urandom_range(20, 80);
          set_config(1'b1, 0, 3, $urandom_range(32'h8000, 32'h40000), total);
        end
      endcase
      run_random_phase(total);
      drain();
    end

    if (errors == 0) begin
      $display("diffusion_step_skip_policy_test: PASS");
    end else begin
      $display("diffusion_step_skip_policy_test: FAIL");
    end
    $finish;
  end

endmodule
